[rtl/core/fcbm_pkg.sv]
// ----------------------------------------------------------------------------
// fcbm_pkg: shared types and constants for the chained-block file manager
// Item layouts, command and status codes, and datapath step codes.
// ----------------------------------------------------------------------------
package fcbm_pkg;

  localparam int NUM_BLOCKS       = 2048;
  localparam int BLOCK_BYTES      = 512;
  localparam int NUM_SLOTS        = 42;
  localparam int FIRST_DATA_BLOCK = 5;
  localparam int NAME_CHARS       = 7;

  localparam int BLK_W  = $clog2(NUM_BLOCKS);
  localparam int OFF_W  = $clog2(BLOCK_BYTES);
  localparam int SLOT_W = $clog2(NUM_SLOTS);
  localparam int CNT_W  = BLK_W + 1;
  localparam int SIZE_W = 16;
  localparam int NAME_W = 8 * NAME_CHARS;

  localparam logic [3:0] CMD_FORMAT  = 4'd0;
  localparam logic [3:0] CMD_CREATE  = 4'd1;
  localparam logic [3:0] CMD_DELETE  = 4'd2;
  localparam logic [3:0] CMD_OPEN_W  = 4'd3;
  localparam logic [3:0] CMD_WRITE   = 4'd4;
  localparam logic [3:0] CMD_CLOSE_W = 4'd5;
  localparam logic [3:0] CMD_OPEN_R  = 4'd6;
  localparam logic [3:0] CMD_READ    = 4'd7;
  localparam logic [3:0] CMD_CLOSE_R = 4'd8;

  localparam logic [3:0] ST_OK         = 4'd0;
  localparam logic [3:0] ST_NONE_OPEN  = 4'd1;
  localparam logic [3:0] ST_WRONG_DIR  = 4'd2;
  localparam logic [3:0] ST_EOF        = 4'd3;
  localparam logic [3:0] ST_EXISTS     = 4'd4;
  localparam logic [3:0] ST_DIR_FULL   = 4'd5;
  localparam logic [3:0] ST_NOT_FOUND  = 4'd6;
  localparam logic [3:0] ST_BUSY       = 4'd7;
  localparam logic [3:0] ST_DISK_FULL  = 4'd8;
  localparam logic [3:0] ST_SIZE_LIMIT = 4'd9;

  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_LOAD  = 2'd1;
  localparam logic [1:0] ACT_FLUSH = 2'd2;

  typedef struct packed {
    logic [3:0]        cmd;
    logic [NAME_W-1:0] file_name;
  } in_item_t;

  typedef struct packed {
    logic [3:0]       status;
    logic [1:0]       disk_action;
    logic [BLK_W-1:0] disk_block;
    logic             byte_valid;
    logic [BLK_W-1:0] byte_block;
    logic [OFF_W-1:0] byte_offset;
  } out_item_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_SCAN_RD,
    OP_SCAN_CMP,
    OP_FMT,
    OP_CREATE,
    OP_TAKE_RD,
    OP_TAKE_WR,
    OP_DEL_DIR,
    OP_DEL_LINK,
    OP_WALK_FIRST,
    OP_WALK_RD,
    OP_WALK_STEP,
    OP_RCROSS_RD,
    OP_FIN_ERR,
    OP_FIN_OK,
    OP_FIN_OPEN_R,
    OP_FIN_OPEN_W,
    OP_FIN_WRITE,
    OP_FIN_WRITE_X,
    OP_FIN_CLOSE_W,
    OP_FIN_CLOSE_R,
    OP_FIN_READ,
    OP_FIN_READ_X
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [3:0] code;
  } dp_cmd_t;

  typedef struct packed {
    logic [3:0] cmd;
    logic       name_zero;
    logic       open_any;
    logic       read_mode;
    logic       size_max;
    logic       size_cross;
    logic       pos_eof;
    logic       pos_cross;
    logic       free_empty;
    logic       scan_last;
    logic       found;
    logic       found_open;
    logic       empty_none;
    logic       fmt_last;
    logic       walk_limit;
    logic       link_zero;
    logic       out_free;
  } dp_stat_t;

  // Keep characters up to the first zero byte.
  function automatic logic [NAME_W-1:0] trim_name(input logic [NAME_W-1:0] n);
    logic [NAME_W-1:0] o;
    logic              live;
    o    = '0;
    live = 1'b1;
    for (int k = 0; k < NAME_CHARS; k++) begin
      if (n[8*k +: 8] == 8'h00) live = 1'b0;
      if (live) o[8*k +: 8] = n[8*k +: 8];
    end
    return o;
  endfunction

endpackage

[rtl/core/fat_chain_file_block_manager.sv]
// ----------------------------------------------------------------------------
// fat_chain_file_block_manager: chained-block file allocator
// Byte and close commands finish after the check; a byte that crosses a block
// first reads the next link (read) or takes a block off the free list (write).
// Create, delete and open scan the directory slot by slot,
// and open-write and delete then walk the link table block by block.
// Format sweeps the link table one entry a cycle.
// One item at a time; reset empties the free list and closes any open file.
// ----------------------------------------------------------------------------
module fat_chain_file_block_manager (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  fcbm_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output fcbm_pkg::out_item_t out_data
);

  fcbm_pkg::dp_cmd_t  dcmd;
  fcbm_pkg::dp_stat_t stat;

  fcbm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .dcmd     (dcmd)
  );

  fcbm_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .dcmd      (dcmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[rtl/core/fcbm_dp.sv]
// ----------------------------------------------------------------------------
// fcbm_dp: datapath of the file manager
// Link table and directory memories, open-file registers and result register.
// ----------------------------------------------------------------------------
module fcbm_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  fcbm_pkg::in_item_t in_data,
  input  fcbm_pkg::dp_cmd_t  dcmd,
  output fcbm_pkg::dp_stat_t stat,
  output logic               out_valid,
  input  logic               out_stall,
  output fcbm_pkg::out_item_t out_data
);

  localparam int BLK_W  = fcbm_pkg::BLK_W;
  localparam int OFF_W  = fcbm_pkg::OFF_W;
  localparam int SLOT_W = fcbm_pkg::SLOT_W;
  localparam int CNT_W  = fcbm_pkg::CNT_W;
  localparam int SIZE_W = fcbm_pkg::SIZE_W;
  localparam int NAME_W = fcbm_pkg::NAME_W;

  logic [BLK_W-1:0]  link_mem  [fcbm_pkg::NUM_BLOCKS];
  logic [NAME_W-1:0] name_mem  [fcbm_pkg::NUM_SLOTS];
  logic [SIZE_W-1:0] size_mem  [fcbm_pkg::NUM_SLOTS];
  logic [BLK_W-1:0]  first_mem [fcbm_pkg::NUM_SLOTS];

  logic [3:0]        cmd_r;
  logic [NAME_W-1:0] name_r;
  logic [SLOT_W-1:0] idx_r, found_r, empty_r;
  logic [BLK_W-1:0]  found_first_r;
  logic [SIZE_W-1:0] found_size_r;
  logic [BLK_W-1:0]  blk_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [BLK_W-1:0]  free_head_r, open_block_r;
  logic [SLOT_W-1:0] open_slot_r;
  logic              read_mode_r;
  logic [SIZE_W-1:0] read_pos_r, open_size_r;
  logic [BLK_W-1:0]  link_rd_r, first_rd_r;
  logic [NAME_W-1:0] name_rd_r;
  logic [SIZE_W-1:0] size_rd_r;
  fcbm_pkg::out_item_t out_r;
  logic              out_valid_r;

  logic              link_re, link_we;
  logic [BLK_W-1:0]  link_ra, link_wa, link_wd, fmt_link;
  logic              dir_re, name_we, size_we, first_we;
  logic [SLOT_W-1:0] dir_ra, dir_wa;
  logic [NAME_W-1:0] name_wd;
  logic [SIZE_W-1:0] size_wd;
  logic [BLK_W-1:0]  first_wd;
  fcbm_pkg::out_item_t res;
  logic              res_load;
  logic              out_free;

  assign out_free = !out_valid_r || !out_stall;

  assign fmt_link = (cnt_r >= CNT_W'(fcbm_pkg::FIRST_DATA_BLOCK) &&
                     cnt_r < CNT_W'(fcbm_pkg::NUM_BLOCKS - 1)) ?
                    BLK_W'(cnt_r + 1'b1) : '0;

  always_comb begin
    link_re  = 1'b0;
    link_ra  = '0;
    link_we  = 1'b0;
    link_wa  = '0;
    link_wd  = '0;
    dir_re   = 1'b0;
    dir_ra   = '0;
    dir_wa   = '0;
    name_we  = 1'b0;
    size_we  = 1'b0;
    first_we = 1'b0;
    name_wd  = '0;
    size_wd  = '0;
    first_wd = '0;
    res      = '0;
    res_load = 1'b0;
    unique case (dcmd.op)
      fcbm_pkg::OP_SCAN_RD: begin
        dir_re = 1'b1;
        dir_ra = idx_r;
      end
      fcbm_pkg::OP_FMT: begin
        link_we = 1'b1;
        link_wa = cnt_r[BLK_W-1:0];
        link_wd = fmt_link;
        if (cnt_r < CNT_W'(fcbm_pkg::NUM_SLOTS)) begin
          dir_wa   = cnt_r[SLOT_W-1:0];
          name_we  = 1'b1;
          size_we  = 1'b1;
          first_we = 1'b1;
        end
      end
      fcbm_pkg::OP_CREATE: begin
        dir_wa   = empty_r;
        name_we  = 1'b1;
        size_we  = 1'b1;
        first_we = 1'b1;
        name_wd  = name_r;
        first_wd = free_head_r;
        link_re  = 1'b1;
        link_ra  = free_head_r;
      end
      fcbm_pkg::OP_TAKE_RD: begin
        link_re = 1'b1;
        link_ra = free_head_r;
      end
      fcbm_pkg::OP_TAKE_WR: begin
        link_we = 1'b1;
        link_wa = blk_r;
      end
      fcbm_pkg::OP_DEL_DIR: begin
        dir_wa   = found_r;
        name_we  = 1'b1;
        size_we  = 1'b1;
        first_we = 1'b1;
      end
      fcbm_pkg::OP_DEL_LINK: begin
        link_we = 1'b1;
        link_wa = blk_r;
        link_wd = found_first_r;
      end
      fcbm_pkg::OP_WALK_RD: begin
        link_re = 1'b1;
        link_ra = blk_r;
      end
      fcbm_pkg::OP_RCROSS_RD: begin
        link_re = 1'b1;
        link_ra = open_block_r;
      end
      fcbm_pkg::OP_FIN_ERR: begin
        res_load   = 1'b1;
        res.status = dcmd.code;
      end
      fcbm_pkg::OP_FIN_OK, fcbm_pkg::OP_FIN_CLOSE_R: begin
        res_load = 1'b1;
      end
      fcbm_pkg::OP_FIN_OPEN_R: begin
        res_load        = 1'b1;
        res.disk_action = fcbm_pkg::ACT_LOAD;
        res.disk_block  = found_first_r;
      end
      fcbm_pkg::OP_FIN_OPEN_W: begin
        res_load        = 1'b1;
        res.disk_action = fcbm_pkg::ACT_LOAD;
        res.disk_block  = blk_r;
      end
      fcbm_pkg::OP_FIN_WRITE: begin
        res_load        = 1'b1;
        res.byte_valid  = 1'b1;
        res.byte_block  = open_block_r;
        res.byte_offset = open_size_r[OFF_W-1:0];
        dir_wa          = open_slot_r;
        size_we         = 1'b1;
        size_wd         = open_size_r + 1'b1;
      end
      fcbm_pkg::OP_FIN_WRITE_X: begin
        // link the new block behind the current one, flush the old buffer
        link_we         = 1'b1;
        link_wa         = open_block_r;
        link_wd         = blk_r;
        res_load        = 1'b1;
        res.disk_action = fcbm_pkg::ACT_FLUSH;
        res.disk_block  = open_block_r;
        res.byte_valid  = 1'b1;
        res.byte_block  = blk_r;
        dir_wa          = open_slot_r;
        size_we         = 1'b1;
        size_wd         = open_size_r + 1'b1;
      end
      fcbm_pkg::OP_FIN_CLOSE_W: begin
        res_load        = 1'b1;
        res.disk_action = fcbm_pkg::ACT_FLUSH;
        res.disk_block  = open_block_r;
      end
      fcbm_pkg::OP_FIN_READ: begin
        res_load        = 1'b1;
        res.byte_valid  = 1'b1;
        res.byte_block  = open_block_r;
        res.byte_offset = read_pos_r[OFF_W-1:0];
      end
      fcbm_pkg::OP_FIN_READ_X: begin
        res_load        = 1'b1;
        res.disk_action = fcbm_pkg::ACT_LOAD;
        res.disk_block  = link_rd_r;
        res.byte_valid  = 1'b1;
        res.byte_block  = link_rd_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (link_we) link_mem[link_wa] <= link_wd;
    if (link_re) link_rd_r <= link_mem[link_ra];
  end

  always_ff @(posedge clk) begin
    if (name_we)  name_mem[dir_wa]  <= name_wd;
    if (size_we)  size_mem[dir_wa]  <= size_wd;
    if (first_we) first_mem[dir_wa] <= first_wd;
    if (dir_re) begin
      name_rd_r  <= name_mem[dir_ra];
      size_rd_r  <= size_mem[dir_ra];
      first_rd_r <= first_mem[dir_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_head_r  <= '0;
      open_slot_r  <= '0;
      open_block_r <= '0;
      read_mode_r  <= 1'b0;
      read_pos_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (dcmd.op)
        fcbm_pkg::OP_FMT: begin
          if (stat.fmt_last) free_head_r <= BLK_W'(fcbm_pkg::FIRST_DATA_BLOCK);
        end
        fcbm_pkg::OP_TAKE_WR: free_head_r <= link_rd_r;
        fcbm_pkg::OP_DEL_DIR: begin
          if (free_head_r == '0) free_head_r <= found_first_r;
        end
        fcbm_pkg::OP_FIN_OPEN_R: begin
          open_slot_r  <= found_r;
          read_mode_r  <= 1'b1;
          read_pos_r   <= '0;
          open_block_r <= found_first_r;
        end
        fcbm_pkg::OP_FIN_OPEN_W: begin
          open_slot_r  <= found_r;
          read_mode_r  <= 1'b0;
          open_block_r <= blk_r;
        end
        fcbm_pkg::OP_FIN_WRITE_X: open_block_r <= blk_r;
        fcbm_pkg::OP_FIN_CLOSE_W, fcbm_pkg::OP_FIN_CLOSE_R: begin
          open_slot_r  <= '0;
          open_block_r <= '0;
        end
        fcbm_pkg::OP_FIN_READ: read_pos_r <= read_pos_r + 1'b1;
        fcbm_pkg::OP_FIN_READ_X: begin
          read_pos_r   <= read_pos_r + 1'b1;
          open_block_r <= link_rd_r;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) out_r <= res;
    unique case (dcmd.op)
      fcbm_pkg::OP_LOAD: begin
        cmd_r   <= in_data.cmd;
        name_r  <= fcbm_pkg::trim_name(in_data.file_name);
        idx_r   <= SLOT_W'(1);
        found_r <= '0;
        empty_r <= '0;
        cnt_r   <= '0;
      end
      fcbm_pkg::OP_SCAN_CMP: begin
        idx_r <= idx_r + 1'b1;
        if (found_r == '0 && name_rd_r == name_r) begin
          found_r       <= idx_r;
          found_first_r <= first_rd_r;
          found_size_r  <= size_rd_r;
        end
        if (empty_r == '0 && name_rd_r[7:0] == 8'h00) empty_r <= idx_r;
      end
      fcbm_pkg::OP_FMT: cnt_r <= cnt_r + 1'b1;
      fcbm_pkg::OP_CREATE, fcbm_pkg::OP_TAKE_RD: blk_r <= free_head_r;
      fcbm_pkg::OP_DEL_DIR: begin
        blk_r <= free_head_r;
        cnt_r <= '0;
      end
      fcbm_pkg::OP_WALK_FIRST: begin
        blk_r <= found_first_r;
        cnt_r <= '0;
      end
      fcbm_pkg::OP_WALK_STEP: begin
        blk_r <= link_rd_r;
        cnt_r <= cnt_r + 1'b1;
      end
      fcbm_pkg::OP_FIN_OPEN_R, fcbm_pkg::OP_FIN_OPEN_W: open_size_r <= found_size_r;
      fcbm_pkg::OP_FIN_WRITE, fcbm_pkg::OP_FIN_WRITE_X: open_size_r <= open_size_r + 1'b1;
      default: begin
      end
    endcase
  end

  always_comb begin
    stat.cmd        = cmd_r;
    stat.name_zero  = (name_r == '0);
    stat.open_any   = (open_slot_r != '0);
    stat.read_mode  = read_mode_r;
    stat.size_max   = &open_size_r;
    stat.size_cross = (open_size_r != '0) && (open_size_r[OFF_W-1:0] == '0);
    stat.pos_eof    = (read_pos_r == open_size_r);
    stat.pos_cross  = (read_pos_r != '0) && (read_pos_r[OFF_W-1:0] == '0);
    stat.free_empty = (free_head_r == '0);
    stat.scan_last  = (idx_r == SLOT_W'(fcbm_pkg::NUM_SLOTS - 1));
    stat.found      = (found_r != '0);
    stat.found_open = (found_r == open_slot_r);
    stat.empty_none = (empty_r == '0);
    stat.fmt_last   = (cnt_r == CNT_W'(fcbm_pkg::NUM_BLOCKS - 1));
    stat.walk_limit = (cnt_r == CNT_W'(fcbm_pkg::NUM_BLOCKS));
    stat.link_zero  = (link_rd_r == '0);
    stat.out_free   = out_free;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[rtl/core/fcbm_ctrl.sv]
// ----------------------------------------------------------------------------
// fcbm_ctrl: command sequencer of the file manager
// Checks each command, then steps the datapath through scans, walks and sweeps.
// ----------------------------------------------------------------------------
module fcbm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  fcbm_pkg::dp_stat_t stat,
  output fcbm_pkg::dp_cmd_t  dcmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISP,
    S_FMT,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SCANNED,
    S_WALK_RD,
    S_WALK_CHK,
    S_TAKE_RD,
    S_TAKE_WR,
    S_RLINK,
    S_FIN
  } state_t;

  state_t            state_r, state_nxt;
  fcbm_pkg::dp_op_t  fin_op_r, fin_op_nxt;
  logic [3:0]        fin_code_r, fin_code_nxt;
  logic              fin_req;
  fcbm_pkg::dp_op_t  fin_op;
  logic [3:0]        fin_code;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    fin_op_nxt   = fin_op_r;
    fin_code_nxt = fin_code_r;
    dcmd.op      = fcbm_pkg::OP_NONE;
    dcmd.code    = fcbm_pkg::ST_OK;
    fin_req      = 1'b0;
    fin_op       = fcbm_pkg::OP_FIN_OK;
    fin_code     = fcbm_pkg::ST_OK;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          dcmd.op   = fcbm_pkg::OP_LOAD;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        fin_op = fcbm_pkg::OP_FIN_ERR;
        unique case (stat.cmd)
          fcbm_pkg::CMD_FORMAT: begin
            if (stat.open_any) begin
              fin_req  = 1'b1;
              fin_code = fcbm_pkg::ST_BUSY;
            end else begin
              state_nxt = S_FMT;
            end
          end
          fcbm_pkg::CMD_CREATE, fcbm_pkg::CMD_DELETE: begin
            if (stat.name_zero) begin
              fin_req  = 1'b1;
              fin_code = fcbm_pkg::ST_NOT_FOUND;
            end else begin
              state_nxt = S_SCAN_RD;
            end
          end
          fcbm_pkg::CMD_OPEN_W, fcbm_pkg::CMD_OPEN_R: begin
            priority if (stat.open_any) begin
              fin_req  = 1'b1;
              fin_code = fcbm_pkg::ST_BUSY;
            end else if (stat.name_zero) begin
              fin_req  = 1'b1;
              fin_code = fcbm_pkg::ST_NOT_FOUND;
            end else begin
              state_nxt = S_SCAN_RD;
            end
          end
          fcbm_pkg::CMD_WRITE: begin
            fin_req = 1'b1;
            priority if (!stat.open_any) begin
              fin_code = fcbm_pkg::ST_NONE_OPEN;
            end else if (stat.read_mode) begin
              fin_code = fcbm_pkg::ST_WRONG_DIR;
            end else if (stat.size_max) begin
              fin_code = fcbm_pkg::ST_SIZE_LIMIT;
            end else if (stat.size_cross && stat.free_empty) begin
              fin_code = fcbm_pkg::ST_DISK_FULL;
            end else if (stat.size_cross) begin
              fin_req   = 1'b0;
              state_nxt = S_TAKE_RD;
            end else begin
              fin_op = fcbm_pkg::OP_FIN_WRITE;
            end
          end
          fcbm_pkg::CMD_CLOSE_W: begin
            fin_req = 1'b1;
            priority if (!stat.open_any) begin
              fin_code = fcbm_pkg::ST_NONE_OPEN;
            end else if (stat.read_mode) begin
              fin_code = fcbm_pkg::ST_WRONG_DIR;
            end else begin
              fin_op = fcbm_pkg::OP_FIN_CLOSE_W;
            end
          end
          fcbm_pkg::CMD_READ: begin
            fin_req = 1'b1;
            priority if (!stat.open_any) begin
              fin_code = fcbm_pkg::ST_NONE_OPEN;
            end else if (!stat.read_mode) begin
              fin_code = fcbm_pkg::ST_WRONG_DIR;
            end else if (stat.pos_eof) begin
              fin_code = fcbm_pkg::ST_EOF;
            end else if (stat.pos_cross) begin
              fin_req   = 1'b0;
              state_nxt = S_RLINK;
            end else begin
              fin_op = fcbm_pkg::OP_FIN_READ;
            end
          end
          fcbm_pkg::CMD_CLOSE_R: begin
            fin_req = 1'b1;
            priority if (!stat.open_any) begin
              fin_code = fcbm_pkg::ST_NONE_OPEN;
            end else if (!stat.read_mode) begin
              fin_code = fcbm_pkg::ST_WRONG_DIR;
            end else begin
              fin_op = fcbm_pkg::OP_FIN_CLOSE_R;
            end
          end
          default: begin
            fin_req = 1'b1;
            fin_op  = fcbm_pkg::OP_FIN_OK;
          end
        endcase
      end
      S_FMT: begin
        dcmd.op = fcbm_pkg::OP_FMT;
        if (stat.fmt_last) begin
          fin_op_nxt   = fcbm_pkg::OP_FIN_OK;
          fin_code_nxt = fcbm_pkg::ST_OK;
          state_nxt    = S_FIN;
        end
      end
      S_SCAN_RD: begin
        dcmd.op   = fcbm_pkg::OP_SCAN_RD;
        state_nxt = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        dcmd.op   = fcbm_pkg::OP_SCAN_CMP;
        state_nxt = stat.scan_last ? S_SCANNED : S_SCAN_RD;
      end
      S_SCANNED: begin
        fin_op = fcbm_pkg::OP_FIN_ERR;
        unique case (stat.cmd)
          fcbm_pkg::CMD_CREATE: begin
            priority if (stat.found) begin
              fin_req  = 1'b1;
              fin_code = fcbm_pkg::ST_EXISTS;
            end else if (stat.empty_none) begin
              fin_req  = 1'b1;
              fin_code = fcbm_pkg::ST_DIR_FULL;
            end else if (stat.free_empty) begin
              fin_req  = 1'b1;
              fin_code = fcbm_pkg::ST_DISK_FULL;
            end else begin
              dcmd.op   = fcbm_pkg::OP_CREATE;
              state_nxt = S_TAKE_WR;
            end
          end
          fcbm_pkg::CMD_DELETE: begin
            priority if (!stat.found) begin
              fin_req  = 1'b1;
              fin_code = fcbm_pkg::ST_NOT_FOUND;
            end else if (stat.found_open) begin
              fin_req  = 1'b1;
              fin_code = fcbm_pkg::ST_BUSY;
            end else if (stat.free_empty) begin
              // chain becomes the whole free list
              dcmd.op      = fcbm_pkg::OP_DEL_DIR;
              fin_op_nxt   = fcbm_pkg::OP_FIN_OK;
              fin_code_nxt = fcbm_pkg::ST_OK;
              state_nxt    = S_FIN;
            end else begin
              dcmd.op   = fcbm_pkg::OP_DEL_DIR;
              state_nxt = S_WALK_RD;
            end
          end
          fcbm_pkg::CMD_OPEN_R: begin
            fin_req = 1'b1;
            if (!stat.found) begin
              fin_code = fcbm_pkg::ST_NOT_FOUND;
            end else begin
              fin_op = fcbm_pkg::OP_FIN_OPEN_R;
            end
          end
          default: begin
            if (!stat.found) begin
              fin_req  = 1'b1;
              fin_code = fcbm_pkg::ST_NOT_FOUND;
            end else begin
              dcmd.op   = fcbm_pkg::OP_WALK_FIRST;
              state_nxt = S_WALK_RD;
            end
          end
        endcase
      end
      S_WALK_RD, S_WALK_CHK: begin
        if ((state_r == S_WALK_RD && stat.walk_limit) ||
            (state_r == S_WALK_CHK && stat.link_zero)) begin
          // chain end reached
          if (stat.cmd == fcbm_pkg::CMD_DELETE) begin
            dcmd.op      = fcbm_pkg::OP_DEL_LINK;
            fin_op_nxt   = fcbm_pkg::OP_FIN_OK;
            fin_code_nxt = fcbm_pkg::ST_OK;
            state_nxt    = S_FIN;
          end else begin
            fin_req = 1'b1;
            fin_op  = fcbm_pkg::OP_FIN_OPEN_W;
          end
        end else if (state_r == S_WALK_RD) begin
          dcmd.op   = fcbm_pkg::OP_WALK_RD;
          state_nxt = S_WALK_CHK;
        end else begin
          dcmd.op   = fcbm_pkg::OP_WALK_STEP;
          state_nxt = S_WALK_RD;
        end
      end
      S_TAKE_RD: begin
        dcmd.op   = fcbm_pkg::OP_TAKE_RD;
        state_nxt = S_TAKE_WR;
      end
      S_TAKE_WR: begin
        dcmd.op      = fcbm_pkg::OP_TAKE_WR;
        fin_op_nxt   = (stat.cmd == fcbm_pkg::CMD_CREATE) ?
                       fcbm_pkg::OP_FIN_OK : fcbm_pkg::OP_FIN_WRITE_X;
        fin_code_nxt = fcbm_pkg::ST_OK;
        state_nxt    = S_FIN;
      end
      S_RLINK: begin
        dcmd.op      = fcbm_pkg::OP_RCROSS_RD;
        fin_op_nxt   = fcbm_pkg::OP_FIN_READ_X;
        fin_code_nxt = fcbm_pkg::ST_OK;
        state_nxt    = S_FIN;
      end
      S_FIN: begin
        if (stat.out_free) begin
          dcmd.op   = fin_op_r;
          dcmd.code = fin_code_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // finish now if the result register is free, else hold the step
    if (fin_req) begin
      if (stat.out_free) begin
        dcmd.op   = fin_op;
        dcmd.code = fin_code;
        state_nxt = S_IDLE;
      end else begin
        fin_op_nxt   = fin_op;
        fin_code_nxt = fin_code;
        state_nxt    = S_FIN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      fin_op_r   <= fcbm_pkg::OP_FIN_OK;
      fin_code_r <= fcbm_pkg::ST_OK;
    end else begin
      state_r    <= state_nxt;
      fin_op_r   <= fin_op_nxt;
      fin_code_r <= fin_code_nxt;
    end
  end

endmodule

[sim/fcbm_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fcbm_checker: result checker for the chained-block file manager
// Mirrors the link table, directory and open-file state, works out the
// answer to each accepted command and compares every returned item with it.
// ----------------------------------------------------------------------------
module fcbm_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  fcbm_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  fcbm_pkg::out_item_t out_data,
  output int                  errors,
  output int                  pending
);

  localparam int BLK_W            = fcbm_pkg::BLK_W;
  localparam int OFF_W            = fcbm_pkg::OFF_W;
  localparam int NAME_W           = fcbm_pkg::NAME_W;
  localparam int NAME_CHARS       = fcbm_pkg::NAME_CHARS;
  localparam int NUM_BLOCKS       = fcbm_pkg::NUM_BLOCKS;
  localparam int NUM_SLOTS        = fcbm_pkg::NUM_SLOTS;
  localparam int FIRST_DATA_BLOCK = fcbm_pkg::FIRST_DATA_BLOCK;

  logic [BLK_W-1:0]  links      [NUM_BLOCKS];
  logic [NAME_W-1:0] dir_name   [NUM_SLOTS];
  logic [15:0]       dir_size   [NUM_SLOTS];
  logic [BLK_W-1:0]  dir_first  [NUM_SLOTS];
  logic [BLK_W-1:0]  free_head;
  int                cur_slot;
  logic [BLK_W-1:0]  cur_block;
  logic              reading;
  logic [15:0]       rd_pos;

  fcbm_pkg::out_item_t answers[$];

  task automatic clear_state();
    foreach (links[i]) links[i] = '0;
    foreach (dir_name[i]) begin
      dir_name[i]  = '0;
      dir_size[i]  = '0;
      dir_first[i] = '0;
    end
    free_head = '0;
    cur_slot  = 0;
    cur_block = '0;
    reading   = 1'b0;
    rd_pos    = '0;
  endtask

  function automatic logic [NAME_W-1:0] name_key(logic [NAME_W-1:0] raw);
    logic [NAME_W-1:0] key;
    key = '0;
    for (int k = 0; k < NAME_CHARS; k++) begin
      if (raw[8*k +: 8] == 8'h00) break;
      key[8*k +: 8] = raw[8*k +: 8];
    end
    return key;
  endfunction

  function automatic int slot_of(logic [NAME_W-1:0] key);
    if (key == '0) return 0;
    for (int i = 1; i < NUM_SLOTS; i++)
      if (dir_name[i] == key) return i;
    return 0;
  endfunction

  function automatic logic [BLK_W-1:0] chain_tail(logic [BLK_W-1:0] b);
    for (int n = 0; n < NUM_BLOCKS; n++) begin
      if (links[b] == '0) break;
      b = links[b];
    end
    return b;
  endfunction

  function automatic logic [BLK_W-1:0] pop_free();
    logic [BLK_W-1:0] b;
    b         = free_head;
    free_head = links[b];
    links[b]  = '0;
    return b;
  endfunction

  // Apply one command to the mirrored state and return its answer.
  function automatic fcbm_pkg::out_item_t file_answer(fcbm_pkg::in_item_t it);
    fcbm_pkg::out_item_t r;
    logic [NAME_W-1:0]   key;
    int                  s;
    logic [BLK_W-1:0]    nb;
    r   = '0;
    key = name_key(it.file_name);
    case (it.cmd)
      fcbm_pkg::CMD_FORMAT: begin
        if (cur_slot != 0) begin
          r.status = fcbm_pkg::ST_BUSY;
        end else begin
          foreach (dir_name[i]) begin
            dir_name[i]  = '0;
            dir_size[i]  = '0;
            dir_first[i] = '0;
          end
          for (int i = 0; i < NUM_BLOCKS; i++)
            links[i] = (i >= FIRST_DATA_BLOCK && i + 1 < NUM_BLOCKS) ? BLK_W'(i + 1) : '0;
          free_head = BLK_W'(FIRST_DATA_BLOCK);
        end
      end
      fcbm_pkg::CMD_CREATE: begin
        s = 0;
        for (int i = 1; i < NUM_SLOTS; i++)
          if (dir_name[i][7:0] == 8'h00) begin
            s = i;
            break;
          end
        if (key == '0) r.status = fcbm_pkg::ST_NOT_FOUND;
        else if (slot_of(key) != 0) r.status = fcbm_pkg::ST_EXISTS;
        else if (s == 0) r.status = fcbm_pkg::ST_DIR_FULL;
        else if (free_head == '0) r.status = fcbm_pkg::ST_DISK_FULL;
        else begin
          dir_name[s]  = key;
          dir_size[s]  = '0;
          dir_first[s] = pop_free();
        end
      end
      fcbm_pkg::CMD_DELETE: begin
        s = slot_of(key);
        if (s == 0) r.status = fcbm_pkg::ST_NOT_FOUND;
        else if (s == cur_slot) r.status = fcbm_pkg::ST_BUSY;
        else begin
          if (free_head == '0) free_head = dir_first[s];
          else links[chain_tail(free_head)] = dir_first[s];
          dir_name[s]  = '0;
          dir_size[s]  = '0;
          dir_first[s] = '0;
        end
      end
      fcbm_pkg::CMD_OPEN_W, fcbm_pkg::CMD_OPEN_R: begin
        s = slot_of(key);
        if (cur_slot != 0) r.status = fcbm_pkg::ST_BUSY;
        else if (s == 0) r.status = fcbm_pkg::ST_NOT_FOUND;
        else begin
          cur_slot = s;
          if (it.cmd == fcbm_pkg::CMD_OPEN_W) begin
            cur_block = chain_tail(dir_first[s]);
            reading   = 1'b0;
          end else begin
            cur_block = dir_first[s];
            reading   = 1'b1;
            rd_pos    = '0;
          end
          r.disk_action = fcbm_pkg::ACT_LOAD;
          r.disk_block  = cur_block;
        end
      end
      fcbm_pkg::CMD_WRITE: begin
        if (cur_slot == 0) r.status = fcbm_pkg::ST_NONE_OPEN;
        else if (reading) r.status = fcbm_pkg::ST_WRONG_DIR;
        else if (dir_size[cur_slot] == 16'hFFFF) r.status = fcbm_pkg::ST_SIZE_LIMIT;
        else if (dir_size[cur_slot] != 0 && dir_size[cur_slot][OFF_W-1:0] == '0
                 && free_head == '0) r.status = fcbm_pkg::ST_DISK_FULL;
        else begin
          // Crossing into a new block: flush the full one and chain a fresh one.
          if (dir_size[cur_slot] != 0 && dir_size[cur_slot][OFF_W-1:0] == '0) begin
            r.disk_action    = fcbm_pkg::ACT_FLUSH;
            r.disk_block     = cur_block;
            nb               = pop_free();
            links[cur_block] = nb;
            cur_block        = nb;
          end
          r.byte_valid       = 1'b1;
          r.byte_block       = cur_block;
          r.byte_offset      = dir_size[cur_slot][OFF_W-1:0];
          dir_size[cur_slot] = dir_size[cur_slot] + 16'd1;
        end
      end
      fcbm_pkg::CMD_CLOSE_W: begin
        if (cur_slot == 0) r.status = fcbm_pkg::ST_NONE_OPEN;
        else if (reading) r.status = fcbm_pkg::ST_WRONG_DIR;
        else begin
          r.disk_action = fcbm_pkg::ACT_FLUSH;
          r.disk_block  = cur_block;
          cur_slot      = 0;
          cur_block     = '0;
        end
      end
      fcbm_pkg::CMD_READ: begin
        if (cur_slot == 0) r.status = fcbm_pkg::ST_NONE_OPEN;
        else if (!reading) r.status = fcbm_pkg::ST_WRONG_DIR;
        else if (rd_pos == dir_size[cur_slot]) r.status = fcbm_pkg::ST_EOF;
        else begin
          if (rd_pos != 0 && rd_pos[OFF_W-1:0] == '0) begin
            cur_block     = links[cur_block];
            r.disk_action = fcbm_pkg::ACT_LOAD;
            r.disk_block  = cur_block;
          end
          r.byte_valid  = 1'b1;
          r.byte_block  = cur_block;
          r.byte_offset = rd_pos[OFF_W-1:0];
          rd_pos        = rd_pos + 16'd1;
        end
      end
      fcbm_pkg::CMD_CLOSE_R: begin
        if (cur_slot == 0) r.status = fcbm_pkg::ST_NONE_OPEN;
        else if (!reading) r.status = fcbm_pkg::ST_WRONG_DIR;
        else begin
          cur_slot  = 0;
          cur_block = '0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic int field_diff(string fname, int want, int got);
    if (want == got) return 0;
    $display("%0t: mismatch on %s: expected %0d, actual %0d", $time, fname, want, got);
    return 1;
  endfunction

  always @(posedge clk) begin : watch
    fcbm_pkg::out_item_t want;
    int                  bad;
    bad = 0;
    if (!rst_n) begin
      clear_state();
      answers.delete();
    end else begin
      if (in_valid && !in_stall) answers.push_back(file_answer(in_data));
      if (out_valid && !out_stall) begin
        if (answers.size() == 0) begin
          $display("%0t: unexpected item: expected none, actual %h", $time, out_data);
          bad = 1;
        end else begin
          want = answers.pop_front();
          bad  = field_diff("status", want.status, out_data.status)
               + field_diff("disk_action", want.disk_action, out_data.disk_action)
               + field_diff("disk_block", want.disk_block, out_data.disk_block)
               + field_diff("byte_valid", want.byte_valid, out_data.byte_valid)
               + field_diff("byte_block", want.byte_block, out_data.byte_block)
               + field_diff("byte_offset", want.byte_offset, out_data.byte_offset);
          bad  = (bad != 0) ? 1 : 0;
        end
      end
    end
    errors  <= errors + bad;
    pending <= answers.size();
  end

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: top level for the chained-block file manager
// Drives directed command checks, random file sessions mixed with noise, a
// directory fill, and one long file that crosses a block boundary.
// ----------------------------------------------------------------------------
module testbench;

  localparam int STALL_LIMIT = 40000;
  localparam int NAME_W      = fcbm_pkg::NAME_W;
  localparam int NAME_CHARS  = fcbm_pkg::NAME_CHARS;
  localparam int NUM_SLOTS   = fcbm_pkg::NUM_SLOTS;

  // Codes outside the command set.
  localparam logic [3:0] CMD_BAD_LO = 4'd9;
  localparam logic [3:0] CMD_BAD_HI = 4'd15;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  fcbm_pkg::in_item_t  in_data   = '0;
  logic                out_stall = 1'b0;
  logic                in_stall;
  logic                out_valid;
  fcbm_pkg::out_item_t out_data;
  int                  errors;
  int                  pending;

  bit                idle_en = 1'b0;
  int                n_sent  = 0;
  int                quiet_cnt = 0;
  logic [NAME_W-1:0] pool_name [8];
  int                pool_len  [8];

  always #5 clk = ~clk;

  fat_chain_file_block_manager u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  fcbm_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .errors    (errors),
    .pending   (pending)
  );

  always @(posedge clk) begin
    out_stall <= idle_en && ($urandom_range(99) < 8);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) begin
      quiet_cnt <= 0;
    end else if (quiet_cnt >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cnt <= quiet_cnt + 1;
    end
  end

  task automatic send(input logic [3:0] c, input logic [NAME_W-1:0] n);
    if (idle_en) begin
      while ($urandom_range(99) < 8) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= '{cmd: c, file_name: n};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [NAME_W-1:0] rand_bits();
    return NAME_W'({$urandom, $urandom});
  endfunction

  // Pool name, with junk after the terminator at random.
  function automatic logic [NAME_W-1:0] pick(int i);
    logic [NAME_W-1:0] junk;
    junk = rand_bits();
    if (pool_len[i] < NAME_CHARS && $urandom_range(1)) begin
      junk = junk << (8 * (pool_len[i] + 1));
      return pool_name[i] | junk;
    end
    return pool_name[i];
  endfunction

  task automatic session(int i, int nbytes, bit del);
    send(fcbm_pkg::CMD_CREATE, pick(i));
    send(fcbm_pkg::CMD_OPEN_W, pick(i));
    repeat (nbytes) send(fcbm_pkg::CMD_WRITE, rand_bits());
    send(fcbm_pkg::CMD_CLOSE_W, rand_bits());
    send(fcbm_pkg::CMD_OPEN_R, pick(i));
    repeat (nbytes + $urandom_range(2)) send(fcbm_pkg::CMD_READ, rand_bits());
    send(fcbm_pkg::CMD_CLOSE_R, rand_bits());
    if (del) send(fcbm_pkg::CMD_DELETE, pick(i));
  endtask

  initial begin : stim
    logic [NAME_W-1:0] nm_a;
    logic [NAME_W-1:0] nm_q;
    logic [3:0]        c;
    int                base;
    int                nb;

    foreach (pool_name[i]) begin
      pool_len[i]  = $urandom_range(1, NAME_CHARS);
      pool_name[i] = '0;
      for (int k = 0; k < pool_len[i]; k++) pool_name[i][8*k +: 8] = 8'($urandom_range(1, 255));
    end
    nm_a = NAME_W'(8'h41);
    nm_q = NAME_W'(8'h71);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Before format only commands that touch the open-file state, and one unknown code.
    send(fcbm_pkg::CMD_WRITE, '0);
    send(fcbm_pkg::CMD_READ, '1);
    send(fcbm_pkg::CMD_CLOSE_W, '0);
    send(fcbm_pkg::CMD_CLOSE_R, '0);
    send(CMD_BAD_HI, '1);
    send(fcbm_pkg::CMD_FORMAT, '0);
    send(fcbm_pkg::CMD_CREATE, nm_a);
    send(fcbm_pkg::CMD_CREATE, nm_a | NAME_W'(56'hFF_FF00_0000_0000));
    send(fcbm_pkg::CMD_CREATE, NAME_W'(56'hFFFF_FFFF_FFFF_00));
    send(fcbm_pkg::CMD_DELETE, '0);
    send(fcbm_pkg::CMD_OPEN_R, NAME_W'(56'h7A7A));
    send(fcbm_pkg::CMD_OPEN_W, nm_a);
    send(fcbm_pkg::CMD_OPEN_R, nm_a);
    send(fcbm_pkg::CMD_FORMAT, '0);
    send(fcbm_pkg::CMD_DELETE, nm_a);
    send(fcbm_pkg::CMD_READ, '0);
    send(fcbm_pkg::CMD_CLOSE_R, '0);
    send(fcbm_pkg::CMD_WRITE, '0);
    send(fcbm_pkg::CMD_WRITE, '1);
    send(fcbm_pkg::CMD_CLOSE_W, '0);
    send(fcbm_pkg::CMD_OPEN_R, nm_a);
    send(fcbm_pkg::CMD_WRITE, '0);
    send(fcbm_pkg::CMD_CLOSE_W, '0);
    repeat (3) send(fcbm_pkg::CMD_READ, '0);
    send(fcbm_pkg::CMD_CLOSE_R, '0);
    send(fcbm_pkg::CMD_DELETE, nm_a);
    send(CMD_BAD_LO, '0);
    drain();

    idle_en = 1'b1;
    base    = n_sent;
    while (n_sent - base < 200) begin
      // Hold a long stretch with no idling on either side.
      idle_en = !((n_sent - base) >= 60 && (n_sent - base) < 140);
      if ($urandom_range(99) < 70) begin
        nb = $urandom_range(0, 12);
        session($urandom_range(7), nb, $urandom_range(1));
      end else begin
        c = 4'($urandom_range(15));
        if (c == fcbm_pkg::CMD_FORMAT && $urandom_range(9) != 0) c = fcbm_pkg::CMD_READ;
        send(c, $urandom_range(1) ? pick($urandom_range(7)) : rand_bits());
      end
      if ($urandom_range(19) == 0) drain();
    end
    idle_en = 1'b1;

    // Fill the directory past its limit, then delete the same names again.
    send(fcbm_pkg::CMD_CLOSE_W, '0);
    send(fcbm_pkg::CMD_CLOSE_R, '0);
    for (int i = 0; i < NUM_SLOTS + 3; i++)
      send(fcbm_pkg::CMD_CREATE, NAME_W'({8'(8'h30 + i), 8'h5A}));
    for (int i = 0; i < NUM_SLOTS + 3; i++)
      send(fcbm_pkg::CMD_DELETE, NAME_W'({8'(8'h30 + i), 8'h5A}));
    drain();

    // One file long enough to chain a second block.
    send(fcbm_pkg::CMD_FORMAT, '0);
    send(fcbm_pkg::CMD_CREATE, nm_q);
    send(fcbm_pkg::CMD_OPEN_W, nm_q);
    repeat (fcbm_pkg::BLOCK_BYTES + 2) send(fcbm_pkg::CMD_WRITE, rand_bits());
    send(fcbm_pkg::CMD_CLOSE_W, '0);
    send(fcbm_pkg::CMD_OPEN_R, nm_q);
    repeat (4) send(fcbm_pkg::CMD_READ, '0);
    send(fcbm_pkg::CMD_CLOSE_R, '0);
    send(fcbm_pkg::CMD_DELETE, nm_q);

    drain();
    repeat (50) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[fat_chain_file_block_manager.f]
rtl/core/fcbm_pkg.sv
rtl/core/fcbm_dp.sv
rtl/core/fcbm_ctrl.sv
rtl/core/fat_chain_file_block_manager.sv
sim/fcbm_checker.sv
sim/testbench.sv
